>>> rtl/core/pcpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpa_pkg: shared definitions of the per-CPU page allocator
// Default sizes, register reset values, register indexes, status codes,
// sequencer states and the address check flags.
// ----------------------------------------------------------------------------
package pcpa_pkg;

	localparam int NUM_CPUS_DEF   = 8;
	localparam int NUM_PAGES_DEF  = 32768;
	localparam int PAGE_BYTES_DEF = 4096;

	localparam logic [6:0] STEAL_CAP = 7'd64;

	localparam logic [31:0] REGION_BASE_RST = 32'h8000_0000;
	localparam logic [31:0] KERNEL_END_RST  = 32'h8000_0000;
	localparam logic [31:0] PHYS_TOP_RST    = 32'h8800_0000;
	localparam logic [6:0]  STEAL_BATCH_RST = 7'd64;

	localparam logic [1:0] REG_REGION_BASE = 2'd0;
	localparam logic [1:0] REG_KERNEL_END  = 2'd1;
	localparam logic [1:0] REG_PHYS_TOP    = 2'd2;
	localparam logic [1:0] REG_STEAL_BATCH = 2'd3;

	localparam logic [1:0] ST_FREED = 2'd0;
	localparam logic [1:0] ST_ALLOC = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_BAD   = 2'd3;

	localparam logic FUNC_FREE  = 1'b0;
	localparam logic FUNC_ALLOC = 1'b1;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_FREE  = 7'b0000010,
		S_ALLOC = 7'b0000100,
		S_POP   = 7'b0001000,
		S_SCAN  = 7'b0010000,
		S_MOVE1 = 7'b0100000,
		S_MOVE2 = 7'b1000000
	} state_t;

	typedef struct packed {
		logic misaligned;
		logic below_kernel;
		logic beyond_top;
		logic below_base;
		logic off_misaligned;
		logic beyond_slots;
	} chk_flags_t;

endpackage

>>> rtl/core/pcpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpa_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; the read data holds until
// the next read is issued.
// ----------------------------------------------------------------------------
module pcpa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/pcpa_heads.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpa_heads: list head registers, one per CPU
// One read index and one write per cycle; reset marks every list empty.
// ----------------------------------------------------------------------------
module pcpa_heads #(
	parameter int NUM_CPUS = 8,
	parameter int NUM_PAGES = 32768,
	localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1,
	localparam int SW = $clog2(NUM_PAGES + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [CW-1:0] rd_idx,
	output logic [SW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [CW-1:0] wr_idx,
	input  logic [SW-1:0] wr_data
);

	localparam logic [SW-1:0] NULL_SLOT = SW'(NUM_PAGES);

	logic [SW-1:0] head_q [NUM_CPUS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CPUS; i++) begin
				head_q[i] <= NULL_SLOT;
			end
		end else if (wr_en) begin
			head_q[wr_idx] <= wr_data;
		end
	end

	assign rd_data = head_q[rd_idx];

endmodule

>>> rtl/core/pcpa_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpa_chk: free address check and slot mapping
// Tests a freed address against alignment and the configured bounds and
// gives the page slot that it maps to.
// ----------------------------------------------------------------------------
module pcpa_chk
	import pcpa_pkg::*;
#(
	parameter int NUM_PAGES = 32768,
	parameter int PAGE_BYTES = 4096,
	localparam int SW = $clog2(NUM_PAGES + 1)
) (
	input  logic [31:0]   addr,
	input  logic [31:0]   region_base,
	input  logic [31:0]   kernel_end,
	input  logic [31:0]   phys_top,
	output chk_flags_t    flags,
	output logic [SW-1:0] slot
);

	localparam int PBL = $clog2(PAGE_BYTES);

	logic [31:0] off;
	logic [31:0] off_pages;

	assign off       = addr - region_base;
	assign off_pages = off >> PBL;

	assign flags.misaligned     = |addr[PBL-1:0];
	assign flags.below_kernel   = addr < kernel_end;
	assign flags.beyond_top     = addr >= phys_top;
	assign flags.below_base     = addr < region_base;
	assign flags.off_misaligned = |off[PBL-1:0];
	assign flags.beyond_slots   = off_pages >= 32'(NUM_PAGES);

	assign slot = off_pages[SW-1:0];

endmodule

>>> rtl/core/per_cpu_page_allocator_with_steal_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_cpu_page_allocator_with_steal_top: per-CPU page allocator with stealing
// Keeps one LIFO free list per CPU as head registers and a next-slot RAM,
// pushes checked pages on free and pops on allocate, stealing from other
// CPUs' lists when the requester's list is empty.
// ----------------------------------------------------------------------------
// A free passes through the FREE state into the output register, and an
// allocation from a non-empty list through the ALLOC and POP states, as the
// next-slot RAM has a single registered read port. An allocation from an
// empty list first walks the other lists in the SCAN state, one list at a
// time, with the MOVE1 and MOVE2 states for each page moved, and at most 64
// pages are moved before it returns to the ALLOC state.
// The block works on one transaction at a time and accepts the next one as
// soon as the previous result sits in the output register. The next-slot
// RAM has no clearing pass.
module per_cpu_page_allocator_with_steal_top
	import pcpa_pkg::*;
#(
	parameter int NUM_CPUS = NUM_CPUS_DEF,
	parameter int NUM_PAGES = NUM_PAGES_DEF,
	parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // cpu [2:0], page_address [34:3], zero fill
	input  logic [0:0]  s_tuser,   // func [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // result_address [31:0]
	output logic [1:0]  m_tuser,   // status [1:0]
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [31:0] wr_data
);

	localparam int CW  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int CNW = $clog2(NUM_CPUS + 1);
	localparam int SW  = $clog2(NUM_PAGES + 1);
	localparam int AW  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int PBL = $clog2(PAGE_BYTES);
	localparam logic [SW-1:0] NULL_SLOT = SW'(NUM_PAGES);

	function automatic logic [CW-1:0] cpu_mod(input logic [2:0] c);
		logic [4:0] v;
		v = {2'b00, c};
		for (int i = 0; i < 8; i++) begin
			if (v >= 5'(NUM_CPUS)) begin
				v = v - 5'(NUM_CPUS);
			end
		end
		return v[CW-1:0];
	endfunction

	function automatic logic [SW-1:0] clamp_slot(input logic [SW-1:0] s);
		return (s > NULL_SLOT) ? NULL_SLOT : s;
	endfunction

	state_t        state_q;
	logic          func_q;
	logic [CW-1:0] cpu_q;
	logic [31:0]   addr_q;
	logic          stolen_q;
	logic [CNW-1:0] idx_q;
	logic [6:0]    left_q;
	logic [SW-1:0] t_q;
	logic          ovalid_q;
	logic [31:0]   oaddr_q;
	logic [1:0]    ostat_q;

	logic [31:0] region_base_q;
	logic [31:0] kernel_end_q;
	logic [31:0] phys_top_q;
	logic [6:0]  steal_batch_q;

	logic          out_free;
	logic          res_load;
	logic [CW-1:0] h_rd_idx;
	logic [SW-1:0] h_rd_data;
	logic          h_we;
	logic [CW-1:0] h_wr_idx;
	logic [SW-1:0] h_wr_data;
	logic          m_we;
	logic [AW-1:0] m_waddr;
	logic [SW-1:0] m_wdata;
	logic          m_re;
	logic [AW-1:0] m_raddr;
	logic [SW-1:0] m_rdata;
	chk_flags_t    flags;
	logic [SW-1:0] free_slot;
	logic          bad;
	logic          head_valid;
	logic          scan_done;

	pcpa_ram #(
		.WIDTH(SW),
		.DEPTH(NUM_PAGES)
	) u_next (
		.clk  (clk),
		.we   (m_we),
		.waddr(m_waddr),
		.wdata(m_wdata),
		.re   (m_re),
		.raddr(m_raddr),
		.rdata(m_rdata)
	);

	pcpa_heads #(
		.NUM_CPUS (NUM_CPUS),
		.NUM_PAGES(NUM_PAGES)
	) u_heads (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (h_rd_idx),
		.rd_data(h_rd_data),
		.wr_en  (h_we),
		.wr_idx (h_wr_idx),
		.wr_data(h_wr_data)
	);

	pcpa_chk #(
		.NUM_PAGES (NUM_PAGES),
		.PAGE_BYTES(PAGE_BYTES)
	) u_chk (
		.addr       (addr_q),
		.region_base(region_base_q),
		.kernel_end (kernel_end_q),
		.phys_top   (phys_top_q),
		.flags      (flags),
		.slot       (free_slot)
	);

	assign bad        = |flags;
	assign out_free   = !ovalid_q || m_tready;
	assign head_valid = h_rd_data < NULL_SLOT;
	assign scan_done  = (left_q == 7'd0) || (idx_q == CNW'(NUM_CPUS));
	assign res_load   = out_free && ((state_q == S_FREE) || (state_q == S_POP) ||
	                    (state_q == S_ALLOC && !head_valid && stolen_q));
	assign s_tready   = (state_q == S_IDLE);
	assign m_tvalid   = ovalid_q;
	assign m_tdata    = oaddr_q;
	assign m_tuser    = ostat_q;

	always_comb begin
		h_rd_idx  = cpu_q;
		h_we      = 1'b0;
		h_wr_idx  = cpu_q;
		h_wr_data = t_q;
		m_we      = 1'b0;
		m_waddr   = t_q[AW-1:0];
		m_wdata   = h_rd_data;
		m_re      = 1'b0;
		m_raddr   = h_rd_data[AW-1:0];
		case (state_q)
			S_FREE: begin
				if (out_free && !bad) begin
					m_we      = 1'b1;
					m_waddr   = free_slot[AW-1:0];
					h_we      = 1'b1;
					h_wr_data = free_slot;
				end
			end
			S_ALLOC: begin
				m_re = head_valid;
			end
			S_POP: begin
				if (out_free) begin
					h_we      = 1'b1;
					h_wr_data = clamp_slot(m_rdata);
				end
			end
			S_SCAN: begin
				h_rd_idx = idx_q[CW-1:0];
				m_re     = !scan_done && (idx_q[CW-1:0] != cpu_q) && head_valid;
			end
			S_MOVE1: begin
				h_rd_idx  = idx_q[CW-1:0];
				h_we      = 1'b1;
				h_wr_idx  = idx_q[CW-1:0];
				h_wr_data = clamp_slot(m_rdata);
			end
			S_MOVE2: begin
				m_we = 1'b1;
				h_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_base_q <= REGION_BASE_RST;
			kernel_end_q  <= KERNEL_END_RST;
			phys_top_q    <= PHYS_TOP_RST;
			steal_batch_q <= STEAL_BATCH_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_REGION_BASE: region_base_q <= wr_data;
				REG_KERNEL_END:  kernel_end_q  <= wr_data;
				REG_PHYS_TOP:    phys_top_q    <= wr_data;
				REG_STEAL_BATCH: steal_batch_q <= wr_data[6:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			stolen_q <= 1'b0;
			idx_q    <= '0;
			left_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (res_load) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						stolen_q <= 1'b0;
						state_q  <= (s_tuser[0] == FUNC_ALLOC) ? S_ALLOC : S_FREE;
					end
				end
				S_FREE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_ALLOC: begin
					if (head_valid) begin
						state_q <= S_POP;
					end else if (!stolen_q) begin
						stolen_q <= 1'b1;
						idx_q    <= '0;
						left_q   <= (steal_batch_q > STEAL_CAP) ? STEAL_CAP : steal_batch_q;
						state_q  <= S_SCAN;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_POP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (scan_done) begin
						state_q <= S_ALLOC;
					end else if ((idx_q[CW-1:0] == cpu_q) || !head_valid) begin
						idx_q <= idx_q + CNW'(1);
					end else begin
						state_q <= S_MOVE1;
					end
				end
				S_MOVE1: begin
					state_q <= S_MOVE2;
				end
				S_MOVE2: begin
					left_q  <= left_q - 7'd1;
					state_q <= S_SCAN;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			func_q <= s_tuser[0];
			cpu_q  <= cpu_mod(s_tdata[2:0]);
			addr_q <= s_tdata[34:3];
		end
		if ((state_q == S_ALLOC && head_valid) ||
		    (state_q == S_SCAN && !scan_done)) begin
			t_q <= h_rd_data;
		end
		if (out_free) begin
			case (state_q)
				S_FREE: begin
					oaddr_q <= 32'd0;
					ostat_q <= (func_q == FUNC_FREE && !bad) ? ST_FREED : ST_BAD;
				end
				S_ALLOC: begin
					oaddr_q <= 32'd0;
					ostat_q <= ST_EMPTY;
				end
				S_POP: begin
					oaddr_q <= region_base_q + (32'(t_q) << PBL);
					ostat_q <= ST_ALLOC;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> bench/tb_per_cpu_page_allocator_with_steal_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_cpu_page_allocator_with_steal_top: self-checking bench of the allocator
// Drives free and allocate transactions with random gaps and output stalls,
// predicts each result with a behavioural copy of the per-CPU free lists and
// compares every result field against it, over several register settings.
// ----------------------------------------------------------------------------
module tb_per_cpu_page_allocator_with_steal_top;
	import pcpa_pkg::*;

	localparam int CPUS = NUM_CPUS_DEF;
	localparam int PAGES = NUM_PAGES_DEF;
	localparam int PAGE_SZ = PAGE_BYTES_DEF;
	localparam logic [15:0] LIST_END = 16'(PAGES);
	localparam int CYCLE_LIMIT = 2_000_000;

	typedef struct packed {
		logic [31:0] addr;
		logic [1:0]  status;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        wr_en = 1'b0;
	logic [1:0]  wr_index = '0;
	logic [31:0] wr_data = '0;

	// Mirror of the block's registers and free lists.
	logic [31:0] base_q = REGION_BASE_RST;
	logic [31:0] kend_q = KERNEL_END_RST;
	logic [31:0] ptop_q = PHYS_TOP_RST;
	logic [6:0]  batch_q = STEAL_BATCH_RST;
	logic [15:0] heads [CPUS];
	logic [15:0] links [PAGES];

	outcome_t    outcome_q [$];
	logic [31:0] held_q [$];

	bit idle_en = 1'b1;
	int hold_cycles = 0;
	int errors = 0;
	int sent_cnt = 0;
	int result_cnt = 0;
	int bad_cnt = 0;
	int empty_cnt = 0;
	int steal_cnt = 0;
	int setting_cnt = 0;
	int cycle_cnt = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	per_cpu_page_allocator_with_steal_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	function automatic logic [15:0] take_head(int c);
		logic [15:0] s;
		s = heads[c];
		if (s < LIST_END) begin
			heads[c] = links[s];
			if (heads[c] > LIST_END)
				heads[c] = LIST_END;
		end
		return s;
	endfunction

	function automatic void put_head(int c, logic [15:0] s);
		links[s] = heads[c];
		heads[c] = s;
	endfunction

	function automatic outcome_t page_outcome(logic func, logic [2:0] cpu, logic [31:0] addr);
		outcome_t    o;
		logic [31:0] off;
		logic [31:0] slot;
		logic        bad;
		int          left;
		int          moved;
		logic [15:0] s;
		o.addr = '0;
		if (func == FUNC_FREE) begin
			off = addr - base_q;
			slot = off / 32'(PAGE_SZ);
			bad = (addr % 32'(PAGE_SZ)) != 0 || addr < kend_q || addr >= ptop_q
				|| addr < base_q || (off % 32'(PAGE_SZ)) != 0 || slot >= 32'(PAGES);
			if (bad) begin
				o.status = ST_BAD;
				bad_cnt++;
			end else begin
				put_head(cpu, slot[15:0]);
				o.status = ST_FREED;
			end
		end else begin
			moved = 0;
			if (heads[cpu] >= LIST_END) begin
				left = (batch_q > STEAL_CAP) ? int'(STEAL_CAP) : int'(batch_q);
				for (int i = 0; i < CPUS && left > 0; i++) begin
					if (i != cpu) begin
						while (left > 0 && heads[i] < LIST_END) begin
							put_head(cpu, take_head(i));
							left--;
							moved++;
						end
					end
				end
			end
			if (moved > 0)
				steal_cnt++;
			s = take_head(cpu);
			if (s < LIST_END) begin
				o.addr = base_q + 32'(s) * 32'(PAGE_SZ);
				o.status = ST_ALLOC;
			end else begin
				o.status = ST_EMPTY;
				empty_cnt++;
			end
		end
		return o;
	endfunction

	function automatic int idle_gap();
		int r;
		if (!idle_en)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [2:0] pick_cpu(bit giver);
		if ($urandom_range(0, 9) < 7)
			return giver ? 3'($urandom_range(0, 3)) : 3'($urandom_range(4, 7));
		return 3'($urandom_range(0, 7));
	endfunction

	task automatic send_op(logic func, logic [2:0] cpu, logic [31:0] addr);
		outcome_t o;
		int       gap;
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {5'b0, addr, cpu};
		do @(posedge clk); while (!s_tready);
		o = page_outcome(func, cpu, addr);
		outcome_q.push_back(o);
		if (o.status == ST_ALLOC)
			held_q.push_back(o.addr);
		sent_cnt++;
		gap = idle_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle(int extra);
		s_tvalid <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic set_config(logic [31:0] rb, logic [31:0] ke, logic [31:0] pt, logic [6:0] sb);
		wait_idle(8);
		wr_en <= 1'b1;
		wr_index <= REG_REGION_BASE;
		wr_data <= rb;
		@(posedge clk);
		wr_index <= REG_KERNEL_END;
		wr_data <= ke;
		@(posedge clk);
		wr_index <= REG_PHYS_TOP;
		wr_data <= pt;
		@(posedge clk);
		wr_index <= REG_STEAL_BATCH;
		wr_data <= {25'b0, sb};
		@(posedge clk);
		wr_en <= 1'b0;
		base_q = rb;
		kend_q = ke;
		ptop_q = pt;
		batch_q = sb;
		held_q.delete();
		setting_cnt++;
		@(posedge clk);
	endtask

	task automatic run_traffic(int n);
		int          r;
		int          idx;
		logic [31:0] addr;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 42) begin
				if (held_q.size() != 0 && $urandom_range(0, 1) == 1) begin
					idx = $urandom_range(0, held_q.size() - 1);
					addr = held_q[idx];
					held_q.delete(idx);
				end else begin
					addr = base_q + 32'($urandom_range(0, PAGES - 1)) * 32'(PAGE_SZ);
				end
				send_op(FUNC_FREE, pick_cpu(1'b1), addr);
			end else if (r < 86) begin
				send_op(FUNC_ALLOC, pick_cpu(1'b0), $urandom);
			end else if (r < 92) begin
				addr = base_q + 32'($urandom_range(0, PAGES - 1)) * 32'(PAGE_SZ)
					+ 32'($urandom_range(1, PAGE_SZ - 1));
				send_op(FUNC_FREE, pick_cpu(1'b1), addr);
			end else if (r < 96) begin
				case ($urandom_range(0, 3))
					0: addr = ptop_q;
					1: addr = ptop_q - 32'(PAGE_SZ);
					2: addr = kend_q - 32'(PAGE_SZ);
					default: addr = base_q + 32'(PAGES) * 32'(PAGE_SZ);
				endcase
				send_op(FUNC_FREE, pick_cpu(1'b1), addr);
			end else begin
				send_op(FUNC_FREE, 3'($urandom_range(0, 7)), $urandom);
			end
		end
	endtask

	// Field extremes, each kind of bad address, stealing and a page freed twice.
	task automatic test_directed();
		send_op(FUNC_ALLOC, 3'd0, 32'h0000_0000);
		send_op(FUNC_FREE, 3'd0, 32'h8000_0000);
		send_op(FUNC_FREE, 3'd7, 32'h87FF_F000);
		send_op(FUNC_FREE, 3'd1, 32'h8800_0000);
		send_op(FUNC_FREE, 3'd2, 32'h7FFF_F000);
		send_op(FUNC_FREE, 3'd3, 32'h8000_0800);
		send_op(FUNC_FREE, 3'd4, 32'hFFFF_FFFF);
		send_op(FUNC_FREE, 3'd5, 32'h0000_0000);
		send_op(FUNC_ALLOC, 3'd0, 32'hFFFF_FFFF);
		send_op(FUNC_ALLOC, 3'd0, 32'h0000_0000);
		send_op(FUNC_FREE, 3'd3, 32'h8000_1000);
		send_op(FUNC_FREE, 3'd3, 32'h8000_1000);
		send_op(FUNC_ALLOC, 3'd3, 32'h0000_0000);
		send_op(FUNC_ALLOC, 3'd3, 32'h0000_0000);
		// Pushing the page once more onto an empty list ends the self loop.
		send_op(FUNC_FREE, 3'd6, 32'h8000_1000);
		send_op(FUNC_ALLOC, 3'd3, 32'h0000_0000);
		send_op(FUNC_ALLOC, 3'd6, 32'h0000_0000);
		send_op(FUNC_ALLOC, 3'd2, 32'h0000_0000);
		send_op(FUNC_FREE, 3'd5, 32'h8000_2000);
		send_op(FUNC_FREE, 3'd5, 32'h8000_3000);
		send_op(FUNC_FREE, 3'd6, 32'h8000_4000);
		send_op(FUNC_ALLOC, 3'd1, 32'h0000_0000);
		send_op(FUNC_ALLOC, 3'd1, 32'h0000_0000);
		send_op(FUNC_ALLOC, 3'd1, 32'h0000_0000);
		wait_idle(4);
	endtask

	// The receiver holds off while the sender keeps offering transactions.
	task automatic test_output_hold();
		idle_en = 1'b0;
		hold_cycles = 300;
		for (int k = 0; k < 16; k++) begin
			if (k % 2 == 0)
				send_op(FUNC_FREE, 3'($urandom_range(0, 7)),
					base_q + 32'($urandom_range(0, PAGES - 1)) * 32'(PAGE_SZ));
			else
				send_op(FUNC_ALLOC, 3'($urandom_range(0, 7)), $urandom);
		end
		idle_en = 1'b1;
		wait_idle(4);
	endtask

	task automatic test_register_settings();
		set_config(32'h0000_0000, 32'h0000_1000, 32'hFFFF_FFFF, 7'd1);
		run_traffic(70);
		set_config(32'hFFF0_0000, 32'h0000_0000, 32'hFFFF_FFFF, 7'd0);
		run_traffic(70);
		set_config(32'h8000_0800, 32'h0000_0000, 32'hFFFF_FFFF, 7'd127);
		run_traffic(70);
		set_config(32'h4000_0000, 32'h4800_0000, 32'h4000_0000, 7'd64);
		run_traffic(70);
		set_config(32'h1000_0000, 32'h1000_4000, 32'h1001_0000, 7'd3);
		run_traffic(70);
		set_config(REGION_BASE_RST, KERNEL_END_RST, PHYS_TOP_RST, STEAL_BATCH_RST);
		run_traffic(70);
	endtask

	task automatic test_random_traffic();
		set_config(REGION_BASE_RST, KERNEL_END_RST, PHYS_TOP_RST, 7'($urandom_range(1, 64)));
		run_traffic(220);
		set_config(REGION_BASE_RST, KERNEL_END_RST, PHYS_TOP_RST, 7'd64);
		idle_en = 1'b0;
		run_traffic(220);
		idle_en = 1'b1;
		set_config(REGION_BASE_RST, KERNEL_END_RST, PHYS_TOP_RST, 7'd1);
		run_traffic(220);
		set_config(32'h8000_0000, 32'h8010_0000, 32'h8400_0000, 7'($urandom_range(0, 127)));
		run_traffic(220);
	endtask

	initial begin : result_side
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
				if (idle_en && $urandom_range(0, 2) == 0)
					stall = idle_gap();
			end
		end
	end

	always @(posedge clk) begin : check_results
		outcome_t o;
		if (arst_n && m_tvalid && m_tready) begin
			if (outcome_q.size() == 0) begin
				$display("%0t: unexpected result, actual address %h status %0d",
					$time, m_tdata, m_tuser);
				errors++;
			end else begin
				o = outcome_q.pop_front();
				result_cnt++;
				if (m_tdata !== o.addr) begin
					$display("%0t: result_address expected %h actual %h",
						$time, o.addr, m_tdata);
					errors++;
				end
				if (m_tuser !== o.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, o.status, m_tuser);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("%0t: run timed out with %0d results outstanding", $time, outcome_q.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		for (int c = 0; c < CPUS; c++)
			heads[c] = LIST_END;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_output_hold();
		test_register_settings();
		test_random_traffic();
		wait_idle(250);
		$display("Covered %0d transactions and %0d checked results over %0d register settings.",
			sent_cnt, result_cnt, setting_cnt);
		$display("Of these %0d were bad frees, %0d empty allocations and %0d allocations stole pages.",
			bad_cnt, empty_cnt, steal_cnt);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
